>>> hw/rtl/replica_source_selector_unit_macros.svh
// Assertion macros used by the replica source selector checker.
`ifndef REPLICA_SOURCE_SELECTOR_UNIT_MACROS_SVH
`define REPLICA_SOURCE_SELECTOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RSS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RSS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/rss_pkg.sv
// Types and constants of the replica source selector.
package rss_pkg;

  localparam int MAX_REPLICAS_DEF = 64;

  localparam int ID_W    = 64;
  localparam int COST_W  = 32;
  localparam int TOTAL_W = 34;
  localparam int IDX_W   = 6;

  // Held slots
  localparam int SLOT_LOCAL  = 0;
  localparam int SLOT_MEM    = 1;
  localparam int SLOT_MEM_OK = 2;
  localparam int SLOT_NOF    = 3;
  localparam int SLOT_LDISK  = 4;
  localparam int SLOT_DISK   = 5;
  localparam int SLOT_BEST   = 6;
  localparam int SLOT_COUNT  = 7;

  // Replica kinds
  localparam logic [2:0] KIND_MEM   = 3'd0;
  localparam logic [2:0] KIND_NOF   = 3'd1;
  localparam logic [2:0] KIND_LDISK = 3'd2;
  localparam logic [2:0] KIND_DISK  = 3'd3;

  // Score verdicts
  localparam logic [1:0] VERDICT_UNSET = 2'd0;
  localparam logic [1:0] VERDICT_SCORE = 2'd1;
  localparam logic [1:0] VERDICT_VETO  = 2'd2;
  localparam logic [1:0] VERDICT_UNAV  = 2'd3;

  // Outcome codes
  localparam logic [3:0] OUT_LOCAL_FAST     = 4'd0;
  localparam logic [3:0] OUT_NO_REMOTE_MEM  = 4'd1;
  localparam logic [3:0] OUT_NO_PROVIDER    = 4'd2;
  localparam logic [3:0] OUT_INVALID_RESULT = 4'd3;
  localparam logic [3:0] OUT_INVALID_SCORE  = 4'd4;
  localparam logic [3:0] OUT_STALE          = 4'd5;
  localparam logic [3:0] OUT_MISSING_SIGNAL = 4'd6;
  localparam logic [3:0] OUT_SOURCE_UNAV    = 4'd7;
  localparam logic [3:0] OUT_SCORED_MEMORY  = 4'd8;
  localparam logic [3:0] OUT_STORAGE        = 4'd9;
  localparam logic [3:0] OUT_NO_SAFE        = 4'd10;

  typedef struct packed {
    logic [ID_W-1:0]   rep_id;
    logic              is_complete;
    logic [2:0]        replica_kind;
    logic              is_local;
    logic [1:0]        verdict_kind;
    logic              cost_invalid;
    logic [COST_W-1:0] topo_cost;
    logic [COST_W-1:0] busy_cost;
    logic [COST_W-1:0] hlth_cost;
    logic [1:0]        unavailable_reason;
    logic              is_last;
  } in_item_t;

  typedef struct packed {
    logic [3:0]       outcome;
    logic             choice_found;
    logic [IDX_W-1:0] choice_index;
    logic [ID_W-1:0]  choice_id;
    logic             baseline_found;
    logic [IDX_W-1:0] baseline_index;
  } out_item_t;

  // Handshake controls from the top level to the scan core
  typedef struct packed {
    logic take;
    logic last;
  } scan_ctl_t;

endpackage

>>> hw/rtl/rss_in_stage.sv
// Input register stage of the replica source selector.
module rss_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  rss_pkg::in_item_t in_item,
  input  logic              take,
  output logic              q_valid,
  output rss_pkg::in_item_t q_item
);
  import rss_pkg::*;

  // Stall while the held item cannot move on
  assign in_stall = q_valid & ~take;

  // Load a new item whenever the register empties or advances
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!q_valid || take) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      q_item <= in_item;
    end
  end

endmodule

>>> hw/rtl/rss_scan.sv
// List scan state and end-of-list decision of the replica source selector.
module rss_scan #(
  parameter int MAX_REPLICAS = rss_pkg::MAX_REPLICAS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_data,
  input  rss_pkg::scan_ctl_t ctl,
  input  rss_pkg::in_item_t  item,
  output rss_pkg::out_item_t res
);
  import rss_pkg::*;

  localparam int POS_W = $clog2(MAX_REPLICAS + 1);

  // Held unavailable reason codes (reason + 1)
  localparam logic [2:0] UNAV_NONE    = 3'd0;
  localparam logic [2:0] UNAV_MISSING = 3'd1;
  localparam logic [2:0] UNAV_STALE   = 3'd2;
  localparam logic [2:0] UNAV_SOURCE  = 3'd3;

  logic                  provider_present;
  logic [POS_W-1:0]      position;
  logic [SLOT_COUNT-1:0] held_valid;
  logic [IDX_W-1:0]      held_index [SLOT_COUNT];
  logic [ID_W-1:0]       held_id [SLOT_COUNT];
  logic [TOTAL_W-1:0]    min_total;
  logic                  candidate_seen;
  logic                  unset_seen;
  logic                  invalid_score_seen;
  logic [2:0]            unavailable_held;

  logic                  held_valid_next [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid_next;
  logic [IDX_W-1:0]      index_next [SLOT_COUNT];
  logic [ID_W-1:0]       id_next [SLOT_COUNT];
  logic [TOTAL_W-1:0]    min_total_next;
  logic                  candidate_seen_next;
  logic                  unset_seen_next;
  logic                  invalid_score_seen_next;
  logic [2:0]            unavailable_held_next;

  logic                  scan_en;
  logic                  hit;
  logic                  is_mem;
  logic                  is_nof;
  logic [TOTAL_W-1:0]    total;
  logic [2:0]            reason_code;
  logic [SLOT_COUNT-1:0] wr;
  logic [IDX_W-1:0]      pos_idx;
  logic [SLOT_COUNT-1:0] base_sel;
  logic [SLOT_COUNT-1:0] skip_sel;
  logic [SLOT_COUNT-1:0] pick_sel;
  logic [3:0]            outcome;

  // Structural choice, one-hot or zero; vetoed selects the slot that skips vetoes
  function automatic logic [SLOT_COUNT-1:0] struct_pick(
    input logic [SLOT_COUNT-1:0] v,
    input logic                  vetoed
  );
    logic [SLOT_COUNT-1:0] p;
    p = '0;
    if (v[SLOT_LOCAL]) begin
      p[SLOT_LOCAL] = 1'b1;
    end else if (vetoed && v[SLOT_MEM_OK]) begin
      p[SLOT_MEM_OK] = 1'b1;
    end else if (!vetoed && v[SLOT_MEM]) begin
      p[SLOT_MEM] = 1'b1;
    end else if (v[SLOT_NOF]) begin
      p[SLOT_NOF] = 1'b1;
    end else if (v[SLOT_LDISK]) begin
      p[SLOT_LDISK] = 1'b1;
    end else if (v[SLOT_DISK]) begin
      p[SLOT_DISK] = 1'b1;
    end
    return p;
  endfunction

  // Decode the item against the current list state
  assign scan_en     = ctl.take & (position < POS_W'(MAX_REPLICAS));
  assign hit         = scan_en & item.is_complete;
  assign is_mem      = item.replica_kind == KIND_MEM;
  assign is_nof      = item.replica_kind == KIND_NOF;
  assign total       = TOTAL_W'(item.topo_cost) + TOTAL_W'(item.busy_cost)
                     + TOTAL_W'(item.hlth_cost);
  assign reason_code = 3'(item.unavailable_reason) + 3'd1;
  assign pos_idx     = IDX_W'(position);

  // Slot write enables: first-seen slots hold once, local disk keeps the last, best keeps the lowest total
  always_comb begin
    wr = '0;
    wr[SLOT_LOCAL]  = hit & (is_mem | is_nof) & item.is_local & ~held_valid[SLOT_LOCAL];
    wr[SLOT_MEM]    = hit & is_mem & ~held_valid[SLOT_MEM];
    wr[SLOT_MEM_OK] = hit & is_mem & (item.verdict_kind != VERDICT_VETO)
                    & ~held_valid[SLOT_MEM_OK];
    wr[SLOT_NOF]    = hit & is_nof & ~held_valid[SLOT_NOF];
    wr[SLOT_LDISK]  = hit & (item.replica_kind == KIND_LDISK);
    wr[SLOT_DISK]   = hit & (item.replica_kind == KIND_DISK) & ~held_valid[SLOT_DISK];
    wr[SLOT_BEST]   = hit & is_mem & (item.verdict_kind == VERDICT_SCORE)
                    & ~item.cost_invalid
                    & (~held_valid[SLOT_BEST] | (total < min_total));
  end

  // Updated slots and flags, including this item
  always_comb begin
    for (int s = 0; s < SLOT_COUNT; s++) begin
      held_valid_next[s] = held_valid[s] | wr[s];
      valid_next[s]      = held_valid_next[s];
      index_next[s]      = wr[s] ? pos_idx : held_index[s];
      id_next[s]         = wr[s] ? item.rep_id : held_id[s];
    end
    min_total_next          = wr[SLOT_BEST] ? total : min_total;
    candidate_seen_next     = candidate_seen | (hit & is_mem);
    unset_seen_next         = unset_seen
                            | (hit & is_mem & (item.verdict_kind == VERDICT_UNSET));
    invalid_score_seen_next = invalid_score_seen
                            | (hit & is_mem & (item.verdict_kind == VERDICT_SCORE)
                               & item.cost_invalid);
    unavailable_held_next   = unavailable_held;
    if (hit && is_mem && (item.verdict_kind == VERDICT_UNAV)
        && (reason_code > unavailable_held)) begin
      unavailable_held_next = reason_code;
    end
  end

  // Decide the outcome and the recommended slot
  always_comb begin
    base_sel = struct_pick(valid_next, 1'b0);
    skip_sel = struct_pick(valid_next, 1'b1);
    pick_sel = base_sel;
    outcome  = OUT_NO_SAFE;
    if (valid_next[SLOT_LOCAL]) begin
      outcome = OUT_LOCAL_FAST;
    end else if (!candidate_seen_next) begin
      outcome = OUT_NO_REMOTE_MEM;
    end else if (!provider_present) begin
      outcome = OUT_NO_PROVIDER;
    end else if (unset_seen_next) begin
      outcome = OUT_INVALID_RESULT;
    end else if (invalid_score_seen_next || (unavailable_held_next != UNAV_NONE)) begin
      pick_sel = skip_sel;
      if (invalid_score_seen_next) begin
        outcome = OUT_INVALID_SCORE;
      end else begin
        case (unavailable_held_next)
          UNAV_MISSING: outcome = OUT_MISSING_SIGNAL;
          UNAV_STALE:   outcome = OUT_STALE;
          UNAV_SOURCE:  outcome = OUT_SOURCE_UNAV;
          default:      outcome = OUT_INVALID_RESULT;
        endcase
      end
    end else if (valid_next[SLOT_BEST]) begin
      pick_sel = '0;
      pick_sel[SLOT_BEST] = 1'b1;
      outcome = OUT_SCORED_MEMORY;
    end else begin
      pick_sel = skip_sel;
      outcome  = (|skip_sel) ? OUT_STORAGE : OUT_NO_SAFE;
    end
  end

  // Gather the result from the selected slots
  always_comb begin
    res                = '0;
    res.outcome        = outcome;
    res.choice_found   = |pick_sel;
    res.baseline_found = |base_sel;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      if (pick_sel[s]) begin
        res.choice_index = res.choice_index | index_next[s];
        res.choice_id    = res.choice_id | id_next[s];
      end
      if (base_sel[s]) begin
        res.baseline_index = res.baseline_index | index_next[s];
      end
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      provider_present <= 1'b1;
    end else if (cfg_write) begin
      provider_present <= cfg_data;
    end
  end

  // Advance list state; clear it after the last item
  always_ff @(posedge clk) begin
    if (rst) begin
      position           <= '0;
      held_valid         <= '0;
      min_total          <= '1;
      candidate_seen     <= 1'b0;
      unset_seen         <= 1'b0;
      invalid_score_seen <= 1'b0;
      unavailable_held   <= UNAV_NONE;
    end else if (ctl.take) begin
      if (ctl.last) begin
        position           <= '0;
        held_valid         <= '0;
        min_total          <= '1;
        candidate_seen     <= 1'b0;
        unset_seen         <= 1'b0;
        invalid_score_seen <= 1'b0;
        unavailable_held   <= UNAV_NONE;
      end else begin
        if (scan_en) begin
          position <= position + POS_W'(1);
        end
        held_valid         <= valid_next;
        min_total          <= min_total_next;
        candidate_seen     <= candidate_seen_next;
        unset_seen         <= unset_seen_next;
        invalid_score_seen <= invalid_score_seen_next;
        unavailable_held   <= unavailable_held_next;
      end
    end
  end

  // Slot payload, no reset
  always_ff @(posedge clk) begin
    for (int s = 0; s < SLOT_COUNT; s++) begin
      if (wr[s]) begin
        held_index[s] <= pos_idx;
        held_id[s]    <= item.rep_id;
      end
    end
  end

endmodule

>>> hw/rtl/rss_out_stage.sv
// Result register stage of the replica source selector.
module rss_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  rss_pkg::out_item_t res,
  output logic               free,
  output logic               out_valid,
  input  logic               out_stall,
  output rss_pkg::out_item_t out_item
);
  import rss_pkg::*;

  // Register can take a new item when empty or being drained
  assign free = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= res;
    end
  end

endmodule

>>> hw/rtl/replica_source_selector_unit.sv
// Top level of the replica source selector.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------
//   in      | input     | in_valid / in_stall | in_item  (one replica)
//   out     | output    | out_valid/out_stall | out_item (one result a list)
//   cfg     | input     | cfg_write           | cfg_data (provider_present)
//
// One item per cycle while no stalled result holds a last item: the scan logic
// updates the list state from the item in the input register, and the last item
// of a list loads its result into the output register in that same cycle.
// Reset is synchronous and clears the list state; provider_present resets to 1.
// A stalled result holds the input register only when it holds a last item.
module replica_source_selector_unit #(
  parameter int MAX_REPLICAS = rss_pkg::MAX_REPLICAS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  rss_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output rss_pkg::out_item_t out_item
);
  import rss_pkg::*;

  logic      q_valid;
  in_item_t  q_item;
  out_item_t res;
  logic      free;
  scan_ctl_t ctl;

  // Move the held item on unless its result has nowhere to go
  assign ctl = '{take: q_valid & (~q_item.is_last | free), last: q_item.is_last};

  rss_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (ctl.take),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  rss_scan #(
    .MAX_REPLICAS (MAX_REPLICAS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .item      (q_item),
    .res       (res)
  );

  rss_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (ctl.take & ctl.last),
    .res       (res),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

>>> hw/rtl/rss_checker.sv
// Port-level assertions for the replica source selector, with their bind.
`include "replica_source_selector_unit_macros.svh"

module rss_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input rss_pkg::out_item_t out_item
);
  import rss_pkg::*;

  // Hold a stalled result
  `RSS_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result dropped")
  `RSS_ASSERT_NXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(out_item), "result changed")

  // No choice means zero index and id
  `RSS_ASSERT_IMP(a_no_choice, clk, rst, out_valid && !out_item.choice_found, (out_item.choice_index == '0) && (out_item.choice_id == '0), "stale choice fields")

  // Local fast and scored memory always recommend a replica
  `RSS_ASSERT_IMP(a_found, clk, rst, out_valid && ((out_item.outcome == OUT_LOCAL_FAST) || (out_item.outcome == OUT_SCORED_MEMORY)), out_item.choice_found && out_item.baseline_found, "missing choice")

endmodule

bind replica_source_selector_unit rss_checker u_rss_checker (.*);
